// File: hw/rtl/tbsp_pkg.sv
// Shared types and constants for the tagged bit-field stream parser.
// No dependencies; imported by tbsp_step and tagged_bitfield_stream_parser.
`timescale 1ns / 1ps
`default_nettype none

package tbsp_pkg;

  localparam int unsigned CharBits  = 7;
  localparam int unsigned LenBits   = 5;
  localparam int unsigned FloatBits = 32;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned CountBits = 6;

  // Result kinds as they appear on the output.
  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_FLOAT = 2'd1;
  localparam logic [1:0] KIND_CHAR  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // Field tags as they appear in the bit stream.
  localparam logic [1:0] TAG_CHAR  = 2'b00;
  localparam logic [1:0] TAG_INT   = 2'b01;
  localparam logic [1:0] TAG_FLOAT = 2'b10;

  typedef enum logic [5:0] {
    PH_TAG_A  = 6'b000001,
    PH_TAG_B  = 6'b000010,
    PH_CHAR   = 6'b000100,
    PH_LEN    = 6'b001000,
    PH_INT    = 6'b010000,
    PH_FLOAT  = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic                   tag_first_bit;
    logic [CountBits-1:0]   bit_count;
    logic [CountBits-1:0]   int_length;
    logic [ValueBits-1:0]   acc;
    logic                   done;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ValueBits-1:0] value;
  } result_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } outq_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/tbsp_step.sv
// Combinational parse of one byte: walks its eight bits MSB first over the parser state.
// Depends on tbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbsp_step (
  input  tbsp_pkg::parse_state_t cur,
  input  logic [7:0]             byte_in,
  output tbsp_pkg::parse_state_t nxt,
  output logic [1:0]             nres,
  output tbsp_pkg::result_t      res0,
  output tbsp_pkg::result_t      res1
);
  import tbsp_pkg::*;

  parse_state_t st;
  logic [1:0]   n;
  result_t      r0;
  result_t      r1;
  logic         bitv;
  logic         emit_en;
  result_t      emit_r;

  always_comb begin
    st      = cur;
    n       = 2'd0;
    r0      = '0;
    r1      = '0;
    bitv    = 1'b0;
    emit_en = 1'b0;
    emit_r  = '0;
    for (int i = 0; i < ByteBits; i++) begin
      bitv    = byte_in[ByteBits-1-i];
      emit_en = 1'b0;
      emit_r  = '0;
      if (!st.done) begin
        case (st.phase)
          PH_TAG_A: begin
            st.tag_first_bit = bitv;
            st.phase         = PH_TAG_B;
          end
          PH_TAG_B: begin
            st.bit_count = '0;
            st.acc       = '0;
            case ({st.tag_first_bit, bitv})
              TAG_CHAR:  st.phase = PH_CHAR;
              TAG_INT:   st.phase = PH_LEN;
              TAG_FLOAT: st.phase = PH_FLOAT;
              default: begin
                emit_en      = 1'b1;
                emit_r.kind  = KIND_END;
                emit_r.value = '0;
                st.phase     = PH_TAG_A;
                st.done      = 1'b1;
              end
            endcase
          end
          PH_CHAR: begin
            st.acc       = {st.acc[ValueBits-2:0], bitv};
            st.bit_count = st.bit_count + 1'b1;
            if (st.bit_count >= CountBits'(CharBits)) begin
              emit_en      = 1'b1;
              emit_r.kind  = KIND_CHAR;
              emit_r.value = {{(ValueBits-CharBits){1'b0}}, st.acc[CharBits-1:0]};
              st.phase     = PH_TAG_A;
              st.bit_count = '0;
              st.acc       = '0;
            end
          end
          PH_LEN: begin
            st.acc       = {st.acc[ValueBits-2:0], bitv};
            st.bit_count = st.bit_count + 1'b1;
            if (st.bit_count >= CountBits'(LenBits)) begin
              st.int_length = {1'b0, st.acc[LenBits-1:0]} + 1'b1;
              st.phase      = PH_INT;
              st.bit_count  = '0;
              st.acc        = '0;
            end
          end
          PH_INT: begin
            st.acc       = {st.acc[ValueBits-2:0], bitv};
            st.bit_count = st.bit_count + 1'b1;
            if (st.bit_count >= st.int_length) begin
              emit_en      = 1'b1;
              emit_r.kind  = KIND_INT;
              emit_r.value = st.acc;
              st.phase     = PH_TAG_A;
              st.bit_count = '0;
              st.acc       = '0;
            end
          end
          PH_FLOAT: begin
            st.acc       = {st.acc[ValueBits-2:0], bitv};
            st.bit_count = st.bit_count + 1'b1;
            if (st.bit_count >= CountBits'(FloatBits)) begin
              emit_en      = 1'b1;
              emit_r.kind  = KIND_FLOAT;
              emit_r.value = st.acc;
              st.phase     = PH_TAG_A;
              st.bit_count = '0;
              st.acc       = '0;
            end
          end
          default: begin
            st.phase     = PH_TAG_A;
            st.bit_count = '0;
            st.acc       = '0;
          end
        endcase
        if (emit_en) begin
          if (n == 2'd0) begin
            r0 = emit_r;
            n  = 2'd1;
          end else if (n == 2'd1) begin
            r1 = emit_r;
            n  = 2'd2;
          end
        end
      end
    end
  end

  assign nxt  = st;
  assign nres = n;
  assign res0 = r0;
  assign res1 = r1;

endmodule

`default_nettype wire

// File: hw/rtl/tagged_bitfield_stream_parser.sv
// A byte accepted into the input register is parsed from there; its results are written to
// the output queue when it commits, which waits for room. One byte per cycle is taken while
// the queue has room; the queue drains one result per cycle while m_axis_tready is high.
// Reset (rst, synchronous, active high) returns the parser to waiting for a tag and empties
// the input register and the output queue.
// Top level of the tagged bit-field stream parser; depends on tbsp_pkg and tbsp_step.
`timescale 1ns / 1ps
`default_nettype none

module tagged_bitfield_stream_parser (
  input  logic        clk,
  input  logic        rst,
  // Input stream: tdata[7:0] = byte_in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Output stream: tdata[31:0] = field_value; tuser[1:0] = kind; tlast = last.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import tbsp_pkg::*;

  // The input register holds one byte. It is parsed in a single combinational pass over
  // its eight bits, and the up to two results land in a four-entry output queue.
  logic         in_valid;
  logic [7:0]   in_byte;
  parse_state_t state;
  parse_state_t state_next;
  logic [1:0]   nres;
  result_t      res0;
  result_t      res1;

  // Output queue: a parsed byte is committed only when two free slots are guaranteed,
  // counting the result leaving this cycle.
  outq_entry_t  outq [4];
  logic [1:0]   wr_ptr;
  logic [1:0]   rd_ptr;
  logic [2:0]   count;
  logic [2:0]   count_after_pop;
  logic         pop;
  logic         commit;

  tbsp_step u_step (
    .cur     (state),
    .byte_in (in_byte),
    .nxt     (state_next),
    .nres    (nres),
    .res0    (res0),
    .res1    (res1)
  );

  assign pop             = m_axis_tvalid && m_axis_tready;
  assign count_after_pop = count - {2'b00, pop};
  assign commit          = in_valid && (count_after_pop <= 3'd2);
  assign s_axis_tready   = !in_valid || commit;

  assign m_axis_tvalid = (count != 3'd0);
  assign m_axis_tdata  = outq[rd_ptr].res.value;
  assign m_axis_tuser  = outq[rd_ptr].res.kind;
  assign m_axis_tlast  = outq[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid            <= 1'b0;
      state.phase         <= PH_TAG_A;
      state.tag_first_bit <= 1'b0;
      state.bit_count     <= '0;
      state.int_length    <= '0;
      state.acc           <= '0;
      state.done          <= 1'b0;
      wr_ptr              <= '0;
      rd_ptr              <= '0;
      count               <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (commit) begin
        in_valid <= 1'b0;
      end
      if (commit) begin
        state  <= state_next;
        wr_ptr <= wr_ptr + nres;
        count  <= count_after_pop + {1'b0, nres};
      end else begin
        count  <= count_after_pop;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Payload: the input byte and the queue contents need no reset.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
    if (commit && (nres != 2'd0)) begin
      // The first result is the final one only when it is alone.
      outq[wr_ptr] <= '{res: res0, last: (nres == 2'd1)};
      if (nres == 2'd2) begin
        outq[wr_ptr + 1'b1] <= '{res: res1, last: 1'b1};
      end
    end
  end

endmodule

`default_nettype wire
